// ===== sv/point_segment_proximity_core_macros.svh =====
// Assertion macros for the proximity core checker.
`ifndef POINT_SEGMENT_PROXIMITY_CORE_MACROS_SVH
`define POINT_SEGMENT_PROXIMITY_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PSP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/psp_pkg.sv =====
// Package: widths, payload structs and cell data types of the proximity core.
`timescale 1ns / 1ps
package psp_pkg;
	localparam int CW     = 16;          // coordinate width
	localparam int DW     = CW + 1;      // coordinate difference width
	localparam int PW     = 2 * DW;      // product width
	localparam int NW     = PW + 1;      // dot product / divider remainder width
	localparam int UF     = 16;          // fractional bits of the projection parameter
	localparam int UW     = UF + 1;      // projection parameter width, covers 1.0
	localparam int SQW    = PW;          // squared distance width
	localparam int RTW    = SQW / 2;     // root width
	localparam int SRW    = RTW + 3;     // root remainder width
	localparam int DCELLS = UW;
	localparam int SCELLS = RTW;

	typedef struct packed {
		logic                 on;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} geo_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [PW-1:0] den;
		logic [UW-1:0] quo;
	} div_t;

	typedef struct packed {
		logic                 on;
		logic signed [CW-1:0] fx;
		logic signed [CW-1:0] fy;
	} foot_t;

	typedef struct packed {
		logic [SQW-1:0] rad;
		logic [SRW-1:0] rem;
		logic [RTW-1:0] root;
	} sqt_t;
endpackage

// ===== sv/psp_query_if.sv =====
// Channel interfaces: query item in, proximity result out.
`timescale 1ns / 1ps
interface psp_query_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   point_x;
	logic signed [15:0]   point_y;
	logic signed [15:0]   start_x;
	logic signed [15:0]   start_y;
	logic signed [15:0]   end_x;
	logic signed [15:0]   end_y;
	modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
		input ready);
	modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
		output ready);
endinterface

interface psp_result_if;
	logic                 valid;
	logic                 ready;
	logic                 on_segment;
	logic signed [15:0]   foot_x;
	logic signed [15:0]   foot_y;
	logic [16:0]          distance;
	modport source (output valid, on_segment, foot_x, foot_y, distance, input ready);
	modport sink (input valid, on_segment, foot_x, foot_y, distance, output ready);
endinterface

// ===== sv/point_segment_proximity_core.sv =====
// Top level: point to line segment proximity pipeline.
`timescale 1ns / 1ps
// Usage:
//   query  (sink)  : point P, segment endpoints S and E, signed Q8.8 each.
//   result (source): on_segment, foot point F (Q8.8) and distance |P-F| (Q9.8,
//                    truncated). Off-segment or zero-length segments give all zeros.
// Throughput: one transaction per cycle, sustained while the output is not stalled.
// Pipeline: a transaction passes 42 registers, set by the two cell rows: 17
//   divider cells (one quotient bit each, u = num/den with 16 fraction bits)
//   and 17 square root cells (one root bit each), plus 8 arithmetic and output
//   stages (differences, dot products, sums, foot multiply, foot add, squares,
//   square sum, output register).
// Stall: the whole pipeline advances together. When the output register holds
//   an untaken result and a new result is ready to land on it, every stage
//   holds; otherwise the pipeline keeps moving and bubbles collapse, so query
//   stays ready while a result waits as long as the slot behind it is empty.
// Reset: arst_n clears all valid bits at once; no result is pending after it.
module point_segment_proximity_core (
	input  logic         clk,
	input  logic         arst_n,
	psp_query_if.sink    query,
	psp_result_if.source result
);
	localparam int CW  = psp_pkg::CW;
	localparam int DW  = psp_pkg::DW;
	localparam int PW  = psp_pkg::PW;
	localparam int NW  = psp_pkg::NW;
	localparam int UF  = psp_pkg::UF;
	localparam int UW  = psp_pkg::UW;
	localparam int RTW = psp_pkg::RTW;

	logic en;

	// stage 1: differences
	logic                 v_s1;
	psp_pkg::geo_t        geo_s1;
	logic signed [DW-1:0] wx_s1, wy_s1;

	// stage 2: products
	logic                 v_s2;
	psp_pkg::geo_t        geo_s2;
	logic signed [PW-1:0] mwx_s2, mwy_s2, mdx_s2, mdy_s2;

	// stage 3: dot product, squared length, range test
	logic                 v_s3;
	psp_pkg::geo_t        geo_s3;
	psp_pkg::div_t        div_s3;
	logic signed [NW-1:0] num_c;
	logic [PW-1:0]        den_c;
	logic                 on_c;

	// divider row
	logic                 dv [0:psp_pkg::DCELLS];
	psp_pkg::div_t        dd [0:psp_pkg::DCELLS];
	psp_pkg::geo_t        dg [0:psp_pkg::DCELLS];

	// stage 4: foot offsets
	logic                 v_s4;
	psp_pkg::geo_t        geo_s4;
	logic signed [PW:0]   prx_s4, pry_s4;

	// stage 5: foot and residual
	logic                 v_s5;
	psp_pkg::foot_t       foot_s5;
	logic signed [CW-1:0] fx_c, fy_c;
	logic signed [DW-1:0] rx_s5, ry_s5;

	// stage 6: squares
	logic                 v_s6;
	psp_pkg::foot_t       foot_s6;
	logic signed [PW-1:0] sqx_s6, sqy_s6;

	// stage 7: squared distance
	logic                 v_s7;
	psp_pkg::foot_t       foot_s7;
	psp_pkg::sqt_t        sqt_s7;

	// square root row
	logic                 sv [0:psp_pkg::SCELLS];
	psp_pkg::sqt_t        sd [0:psp_pkg::SCELLS];
	psp_pkg::foot_t       sf [0:psp_pkg::SCELLS];

	// output register
	logic                 out_v_q;
	logic                 on_q;
	logic signed [CW-1:0] fx_q, fy_q;
	logic [RTW-1:0]       dist_q;

	// Hold everything only when a finished result would overwrite an untaken one.
	assign en          = !out_v_q || result.ready || !sv[psp_pkg::SCELLS];
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv[psp_pkg::DCELLS];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Range test on the exact ratio; a zero-length segment is off-segment.
	always_comb begin
		num_c = {mwx_s2[PW-1], mwx_s2} + {mwy_s2[PW-1], mwy_s2};
		den_c = mdx_s2[PW-1:0] + mdy_s2[PW-1:0];
		on_c  = (den_c != '0) && !num_c[NW-1] && (num_c[PW-1:0] <= den_c);
	end

	// Foot: S + floor(d*u / 2^UF); the foot stays between S and E.
	always_comb begin
		fx_c = geo_s4.sx + prx_s4[CW+UF-1:UF];
		fy_c = geo_s4.sy + pry_s4[CW+UF-1:UF];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.on <= 1'b0;
			geo_s1.px <= query.point_x;
			geo_s1.py <= query.point_y;
			geo_s1.sx <= query.start_x;
			geo_s1.sy <= query.start_y;
			geo_s1.dx <= {query.end_x[CW-1], query.end_x} - {query.start_x[CW-1], query.start_x};
			geo_s1.dy <= {query.end_y[CW-1], query.end_y} - {query.start_y[CW-1], query.start_y};
			wx_s1     <= {query.point_x[CW-1], query.point_x}
				- {query.start_x[CW-1], query.start_x};
			wy_s1     <= {query.point_y[CW-1], query.point_y}
				- {query.start_y[CW-1], query.start_y};

			geo_s2 <= geo_s1;
			mwx_s2 <= PW'(wx_s1) * PW'(geo_s1.dx);
			mwy_s2 <= PW'(wy_s1) * PW'(geo_s1.dy);
			mdx_s2 <= PW'(geo_s1.dx) * PW'(geo_s1.dx);
			mdy_s2 <= PW'(geo_s1.dy) * PW'(geo_s1.dy);

			geo_s3.on  <= on_c;
			geo_s3.px  <= geo_s2.px;
			geo_s3.py  <= geo_s2.py;
			geo_s3.sx  <= geo_s2.sx;
			geo_s3.sy  <= geo_s2.sy;
			geo_s3.dx  <= geo_s2.dx;
			geo_s3.dy  <= geo_s2.dy;
			// Off-segment items run through the divider with a zero remainder; the result is masked.
			div_s3.rem <= on_c ? num_c : '0;
			div_s3.den <= den_c;
			div_s3.quo <= '0;

			geo_s4 <= dg[psp_pkg::DCELLS];
			prx_s4 <= NW'(dg[psp_pkg::DCELLS].dx)
				* NW'($signed({1'b0, dd[psp_pkg::DCELLS].quo}));
			pry_s4 <= NW'(dg[psp_pkg::DCELLS].dy)
				* NW'($signed({1'b0, dd[psp_pkg::DCELLS].quo}));

			foot_s5.on <= geo_s4.on;
			foot_s5.fx <= fx_c;
			foot_s5.fy <= fy_c;
			rx_s5      <= {geo_s4.px[CW-1], geo_s4.px} - {fx_c[CW-1], fx_c};
			ry_s5      <= {geo_s4.py[CW-1], geo_s4.py} - {fy_c[CW-1], fy_c};

			foot_s6 <= foot_s5;
			sqx_s6  <= PW'(rx_s5) * PW'(rx_s5);
			sqy_s6  <= PW'(ry_s5) * PW'(ry_s5);

			foot_s7      <= foot_s6;
			sqt_s7.rad   <= sqx_s6[PW-1:0] + sqy_s6[PW-1:0];
			sqt_s7.rem   <= '0;
			sqt_s7.root  <= '0;
		end
	end

	assign dv[0] = v_s3;
	assign dd[0] = div_s3;
	assign dg[0] = geo_s3;

	for (genvar i = 0; i < psp_pkg::DCELLS; i++) begin : g_div
		psp_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (dv[i]),
			.d_in   (dd[i]),
			.g_in   (dg[i]),
			.v_out  (dv[i+1]),
			.d_out  (dd[i+1]),
			.g_out  (dg[i+1])
		);
	end

	assign sv[0] = v_s7;
	assign sd[0] = sqt_s7;
	assign sf[0] = foot_s7;

	for (genvar i = 0; i < psp_pkg::SCELLS; i++) begin : g_sqrt
		psp_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (sv[i]),
			.d_in   (sd[i]),
			.f_in   (sf[i]),
			.v_out  (sv[i+1]),
			.d_out  (sd[i+1]),
			.f_out  (sf[i+1])
		);
	end

	// Load a new result when the pipeline advances; drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en && sv[psp_pkg::SCELLS]) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Zero every field of an off-segment result.
	always_ff @(posedge clk) begin
		if (en && sv[psp_pkg::SCELLS]) begin
			on_q   <= sf[psp_pkg::SCELLS].on;
			fx_q   <= sf[psp_pkg::SCELLS].on ? sf[psp_pkg::SCELLS].fx : '0;
			fy_q   <= sf[psp_pkg::SCELLS].on ? sf[psp_pkg::SCELLS].fy : '0;
			dist_q <= sf[psp_pkg::SCELLS].on ? sd[psp_pkg::SCELLS].root : '0;
		end
	end

	assign result.valid      = out_v_q;
	assign result.on_segment = on_q;
	assign result.foot_x     = fx_q;
	assign result.foot_y     = fy_q;
	assign result.distance   = dist_q;
endmodule

// ===== sv/psp_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit per stage.
`timescale 1ns / 1ps
module psp_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  psp_pkg::div_t  d_in,
	input  psp_pkg::geo_t  g_in,
	output logic           v_out,
	output psp_pkg::div_t  d_out,
	output psp_pkg::geo_t  g_out
);
	logic [psp_pkg::NW-1:0] den_ext;
	logic [psp_pkg::NW-1:0] diff;
	logic [psp_pkg::NW-1:0] r_sel;
	logic                   ge;
	psp_pkg::div_t          nxt;

	always_comb begin
		den_ext = {1'b0, d_in.den};
		ge      = d_in.rem >= den_ext;
		diff    = d_in.rem - den_ext;
		r_sel   = ge ? diff : d_in.rem;
		nxt.rem = {r_sel[psp_pkg::NW-2:0], 1'b0};
		nxt.den = d_in.den;
		nxt.quo = {d_in.quo[psp_pkg::UW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
			g_out <= g_in;
		end
	end
endmodule

// ===== sv/psp_sqrt_cell.sv =====
// One integer square root cell: consumes two radicand bits, yields one root bit.
`timescale 1ns / 1ps
module psp_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  psp_pkg::sqt_t  d_in,
	input  psp_pkg::foot_t f_in,
	output logic           v_out,
	output psp_pkg::sqt_t  d_out,
	output psp_pkg::foot_t f_out
);
	logic [psp_pkg::SRW-1:0] cur;
	logic [psp_pkg::SRW-1:0] trial;
	logic                    ge;
	psp_pkg::sqt_t           nxt;

	always_comb begin
		cur      = {d_in.rem[psp_pkg::SRW-3:0], d_in.rad[psp_pkg::SQW-1:psp_pkg::SQW-2]};
		trial    = {1'b0, d_in.root, 2'b01};
		ge       = cur >= trial;
		nxt.rem  = ge ? (cur - trial) : cur;
		nxt.root = {d_in.root[psp_pkg::RTW-2:0], ge};
		nxt.rad  = {d_in.rad[psp_pkg::SQW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
			f_out <= f_in;
		end
	end
endmodule

// ===== sv/psp_checker.sv =====
// Port-level checker for the proximity core, bound to the top level.
`timescale 1ns / 1ps
`include "point_segment_proximity_core_macros.svh"
module psp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_on,
	input logic signed [15:0] res_fx,
	input logic signed [15:0] res_fy,
	input logic [16:0]        res_dist
);
	`PSP_ASSERT_NEXT(a_hold_valid, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`PSP_ASSERT_NEXT(a_hold_data, res_valid && !res_ready, $stable({res_on, res_fx, res_fy, res_dist}), "result changed while stalled")
	`PSP_ASSERT_SAME(a_off_zero, res_valid && !res_on, res_fx == 16'sd0 && res_fy == 16'sd0 && res_dist == 17'd0, "off-segment result not zero")
	`PSP_ASSERT_SAME(a_dist_range, res_valid && res_on, res_dist <= 17'd92682, "distance out of range")
endmodule

bind point_segment_proximity_core psp_checker u_psp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_on    (result.on_segment),
	.res_fx    (result.foot_x),
	.res_fy    (result.foot_y),
	.res_dist  (result.distance)
);

// ===== bench/point_segment_proximity_core_tb.sv =====
// Testbench: random and directed stimulus for the point to segment proximity core.
`timescale 1ns / 1ps
module point_segment_proximity_core_tb;
	localparam int LATENCY = 42;
	localparam int N_RANDOM = 1400;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} query_t;

	typedef struct packed {
		logic               on;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic [16:0]        distance;
	} proximity_t;

	logic clk;
	logic arst_n;
	psp_query_if  query();
	psp_result_if result();

	point_segment_proximity_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query.sink),
		.result (result.source)
	);

	query_t     pending_queries[$];
	proximity_t expected_results[$];
	int         n_errors;
	int         n_checked;
	int         n_on;
	longint     n_cycles;
	bit         stim_done;
	bit         hold_sender;
	bit         q_taken;
	int         burst_left;
	int         gap_left;
	int         stall_phase;

	// Floor of the square root, bit by bit.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Floor division by 2^16, exact for negative values.
	function automatic longint floor_u(longint t);
		if (t >= 0)
			return t >>> 16;
		return -((-t + 65535) >>> 16);
	endfunction

	// Project the point onto the segment and measure the distance to the foot.
	function automatic proximity_t project_point(query_t q);
		proximity_t r;
		longint dx, dy, wx, wy, num, den, u, fx, fy, rx, ry;
		longint unsigned sq;
		r = '0;
		dx = longint'(q.ex) - longint'(q.sx);
		dy = longint'(q.ey) - longint'(q.sy);
		wx = longint'(q.px) - longint'(q.sx);
		wy = longint'(q.py) - longint'(q.sy);
		num = wx * dx + wy * dy;
		den = dx * dx + dy * dy;
		if (den == 0 || num < 0 || num > den)
			return r;
		u = (num << 16) / den;
		fx = longint'(q.sx) + floor_u(dx * u);
		fy = longint'(q.sy) + floor_u(dy * u);
		rx = longint'(q.px) - fx;
		ry = longint'(q.py) - fy;
		sq = longint'(rx * rx) + longint'(ry * ry);
		r.on = 1'b1;
		r.fx = fx[15:0];
		r.fy = fy[15:0];
		r.distance = 17'(int_sqrt(sq));
		return r;
	endfunction

	function automatic query_t mk(int px, int py, int sx, int sy, int ex, int ey);
		query_t q;
		q.px = 16'(px); q.py = 16'(py); q.sx = 16'(sx);
		q.sy = 16'(sy); q.ex = 16'(ex); q.ey = 16'(ey);
		return q;
	endfunction

	function automatic logic [15:0] rnd_coord(int span);
		if (span == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Count cycles and stop a run that hangs.
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("point_segment_proximity_core_tb failed");
			$finish;
		end
	end

	// Driver: present items in bursts, with random gaps between them.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query.valid <= 1'b0;
			burst_left  <= 0;
			gap_left    <= 0;
		end else begin
			if (q_taken)
				void'(pending_queries.pop_front());
			if (query.valid && !q_taken) begin
				// hold the untaken transaction
			end else if (hold_sender || pending_queries.size() == 0) begin
				query.valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left    <= gap_left - 1;
				query.valid <= 1'b0;
			end else begin
				query.valid   <= 1'b1;
				query.point_x <= pending_queries[0].px;
				query.point_y <= pending_queries[0].py;
				query.start_x <= pending_queries[0].sx;
				query.start_y <= pending_queries[0].sy;
				query.end_x   <= pending_queries[0].ex;
				query.end_y   <= pending_queries[0].ey;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Receiver stalls on a repeating pattern: a phase of full rate, then random stalls.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_phase  <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase < 30)
				result.ready <= 1'b1;
			else if (stall_phase < 60)
				result.ready <= ($urandom_range(0, 3) != 0);
			else
				result.ready <= (stall_phase % 5 != 0) && ($urandom_range(0, 1) == 1);
		end
	end

	// Monitor: record predictions at acceptance, compare results at acceptance.
	always @(posedge clk) begin
		proximity_t exp_r;
		q_taken <= arst_n && query.valid && query.ready;
		if (arst_n) begin
			if (query.valid && query.ready)
				expected_results.push_back(project_point(pending_queries[0]));
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected");
					n_errors++;
				end else begin
					exp_r = expected_results.pop_front();
					n_checked++;
					if (exp_r.on) n_on++;
					if (result.on_segment !== exp_r.on) begin
						$error("on_segment: expected %0d, got %0d", exp_r.on, result.on_segment);
						n_errors++;
					end
					if (result.foot_x !== exp_r.fx) begin
						$error("foot_x: expected %0d, got %0d", exp_r.fx, result.foot_x);
						n_errors++;
					end
					if (result.foot_y !== exp_r.fy) begin
						$error("foot_y: expected %0d, got %0d", exp_r.fy, result.foot_y);
						n_errors++;
					end
					if (result.distance !== exp_r.distance) begin
						$error("distance: expected %0d, got %0d", exp_r.distance,
							result.distance);
						n_errors++;
					end
				end
			end
		end
	end

	initial begin
		query_t q;
		int     sx, sy, ex, ey, span;
		longint t;
		n_errors = 0; n_checked = 0; n_on = 0; n_cycles = 0;
		stim_done = 0; hold_sender = 0; q_taken = 0;
		query.valid = 1'b0;
		query.point_x = '0; query.point_y = '0; query.start_x = '0;
		query.start_y = '0; query.end_x = '0; query.end_y = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: zero-length, ends, just outside, extremes, tiny negative u.
		pending_queries.push_back(mk(100, 100, 5, 5, 5, 5));
		pending_queries.push_back(mk(0, 0, 0, 0, 0, 0));
		pending_queries.push_back(mk(0, 256, 0, 0, 512, 0));
		pending_queries.push_back(mk(512, 256, 0, 0, 512, 0));
		pending_queries.push_back(mk(0, 256, 1, 0, 512, 0));
		pending_queries.push_back(mk(513, 256, 0, 0, 512, 0));
		pending_queries.push_back(mk(-1, 0, 0, 0, 512, 0));
		pending_queries.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767));
		pending_queries.push_back(mk(32767, -32768, -32768, -32768, 32767, 32767));
		pending_queries.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767));
		pending_queries.push_back(mk(32767, 32767, 32767, -32768, -32768, 32767));
		pending_queries.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768));
		pending_queries.push_back(mk(0, 0, -32768, 0, 32767, 1));
		pending_queries.push_back(mk(0, 32767, -32768, -32768, 32767, -32768));
		pending_queries.push_back(mk(0, 0, 0, -32768, 1, 32767));
		pending_queries.push_back(mk(7, -3, 1, 1, 2, 2));
		pending_queries.push_back(mk(100, 333, -77, 12, 911, -400));
		pending_queries.push_back(mk(-1, -1, 0, 0, 1, 0));
		pending_queries.push_back(mk(1, 100, 0, 0, 1, 1));
		pending_queries.push_back(mk(-32768, 32767, 32767, -32768, 32767, -32767));

		// Random: mostly points near the segment so many results land on it.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// drain everything before continuing
				wait (pending_queries.size() == 0);
				hold_sender = 1;
				wait (expected_results.size() == 0);
				@(negedge clk) hold_sender = 0;
			end
			case ($urandom_range(0, 5))
				0: span = 0;
				1: span = 8;
				2: span = 300;
				default: span = 4000;
			endcase
			q.sx = rnd_coord(span);
			q.sy = rnd_coord(span);
			if ($urandom_range(0, 30) == 0) begin
				q.ex = q.sx; q.ey = q.sy;
			end else begin
				q.ex = rnd_coord(span);
				q.ey = rnd_coord(span);
			end
			if ($urandom_range(0, 3) == 0) begin
				q.px = rnd_coord(span);
				q.py = rnd_coord(span);
			end else begin
				// point near a random spot along the segment, kept in range
				t = $urandom_range(0, 1024);
				sx = q.sx + ((longint'(q.ex) - q.sx) * t) / 1024;
				sy = q.sy + ((longint'(q.ey) - q.sy) * t) / 1024;
				ex = sx + $urandom_range(0, 600) - 300;
				ey = sy + $urandom_range(0, 600) - 300;
				q.px = (ex > 32767) ? 32767 : (ex < -32768) ? -32768 : ex;
				q.py = (ey > 32767) ? 32767 : (ey < -32768) ? -32768 : ey;
			end
			pending_queries.push_back(q);
			if (pending_queries.size() > 64)
				wait (pending_queries.size() < 32);
		end
		wait (pending_queries.size() == 0);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("checked %0d results, %0d of them on the segment", n_checked, n_on);
		$display("covered degenerate segments, endpoint and full-range coordinates, stalls");
		if (n_errors == 0)
			$display("point_segment_proximity_core_tb passed");
		else
			$display("point_segment_proximity_core_tb failed");
		$finish;
	end
endmodule
